// File: sv/fci_pkg.sv
// fci_pkg: widths, register indexes, shared types and the temperature scaling
// function of the fan curve interpolator
// no dependencies
package fci_pkg;

	localparam int TEMP_W      = 8;   // curve point temperature, whole degrees
	localparam int DUTY_W      = 9;   // duty registers and output duty
	localparam int TEMPC_W     = 15;  // sample, hundredths of a degree
	localparam int SEG_W       = 3;
	localparam int X_W         = 16;  // scaled temperatures and sample, signed
	localparam int DEN_W       = 15;  // segment width in hundredths, unsigned
	localparam int DY_W        = 10;  // duty difference, signed
	localparam int NUM_W       = 24;  // numerator, always non-negative
	localparam int P2_W        = 26;  // signed slope product
	localparam int Q_W         = 9;   // quotient bits, num < 512 * den
	localparam int NUM_PTS_MAX = 4;
	localparam int PT_IDX_W    = 2;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 9;
	localparam int S_DATA_W    = 16;
	localparam int M_DATA_W    = 16;

	localparam logic signed [X_W-1:0] TEMP_SCALE = 16'sd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT0_TEMP = 4'd0,
		REG_POINT1_TEMP = 4'd1,
		REG_POINT2_TEMP = 4'd2,
		REG_POINT3_TEMP = 4'd3,
		REG_POINT0_DUTY = 4'd4,
		REG_POINT1_DUTY = 4'd5,
		REG_POINT2_DUTY = 4'd6,
		REG_POINT3_DUTY = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_PTS_MAX-1:0][TEMP_W-1:0] temp;
		logic [NUM_PTS_MAX-1:0][DUTY_W-1:0] duty;
	} curve_t;

	localparam curve_t CURVE_RESET = '{
		temp: {8'd60, 8'd50, 8'd40, 8'd30},
		duty: {9'd256, 9'd192, 9'd128, 9'd64}
	};

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic [SEG_W-1:0] seg;
	} div_req_t;

	typedef struct packed {
		logic [SEG_W-1:0]  seg;
		logic [DUTY_W-1:0] duty;
	} result_t;

	// whole degrees to hundredths, exact in 16 bits signed
	function automatic logic signed [X_W-1:0] scale_temp(input logic signed [TEMP_W-1:0] tc);
		logic signed [X_W-1:0] ext;
		ext = X_W'(tc);
		return ext * TEMP_SCALE;
	endfunction

endpackage

// File: sv/fan_curve_interpolator_unit.sv
// fan_curve_interpolator_unit: top level of the four-point fan curve interpolator
// depends on fci_pkg, fci_cfg_regs, fci_front, fci_divider, fci_out_skid
//
// channel   dir  handshake             payload
// s_        in   s_tvalid / s_tready   s_tdata[14:0] temperature_centi
// m_        out  m_tvalid / m_tready   m_tdata[8:0] duty, [11:9] segment
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// one request per cycle sustained while m_tready keeps the skid entry free; the path
// is four front stages, nine divider stages (one quotient bit each) and the
// output register
// arst_n clears all valid bits and loads the curve reset values
// a stall at m_ tready parks one result in the skid entry; s_tready then drops
// and the whole pipeline holds until the skid entry drains
// cfg_ready is always high; write registers only while the pipeline is empty
module fan_curve_interpolator_unit import fci_pkg::*; #(
	parameter int NUM_POINTS = 4,
	parameter int DUTY_MAX   = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// temperature sample requests
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,   // [14:0] temperature_centi, [15] unused
	// duty results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,   // [8:0] duty, [11:9] segment, [15:12] zero
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [DUTY_W-1:0] DUTY_CLAMP = DUTY_W'(DUTY_MAX);

	curve_t            curve;
	logic              pipe_en;
	logic              front_valid;
	div_req_t          front_req;
	logic              div_valid;
	logic [Q_W-1:0]    div_quo;
	logic [SEG_W-1:0]  div_seg;
	result_t           res_c;
	result_t           m_res;

	fci_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.curve     (curve)
	);

	// the pipeline moves as a whole whenever the skid entry is free
	assign s_tready = pipe_en;

	fci_front #(
		.NUM_POINTS (NUM_POINTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (pipe_en),
		.in_valid   (s_tvalid),
		.temp_centi (signed'(s_tdata[TEMPC_W-1:0])),
		.curve      (curve),
		.out_valid  (front_valid),
		.out_req    (front_req)
	);

	fci_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (front_valid),
		.in_req    (front_req),
		.out_valid (div_valid),
		.out_quo   (div_quo),
		.out_seg   (div_seg)
	);

	// clamp to 1..DUTY_MAX, then keep the low nine bits
	always_comb begin
		res_c.seg = div_seg;
		if (div_quo == '0) begin
			res_c.duty = DUTY_W'(1);
		end else if (32'(div_quo) > DUTY_MAX) begin
			res_c.duty = DUTY_CLAMP;
		end else begin
			res_c.duty = div_quo;
		end
	end

	fci_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (div_valid),
		.res       (res_c),
		.pipe_en   (pipe_en),
		.m_valid   (m_tvalid),
		.m_ready   (m_tready),
		.m_res     (m_res)
	);

	assign m_tdata = {{(M_DATA_W - SEG_W - DUTY_W){1'b0}}, m_res.seg, m_res.duty};

	// a result never reports a segment past the last point
	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[11:9]) <= NUM_POINTS))
		else $error("segment beyond last curve point");

	// the clamp keeps the duty off zero
	a_duty_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[8:0] != '0))
		else $error("zero duty delivered");

	// input backpressure only while a result is parked behind the output register
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// a point0 temperature write lands in the curve on the next cycle
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && cfg_index == REG_POINT0_TEMP)
		|=> (curve.temp[0] == $past(cfg_data[TEMP_W-1:0])))
		else $error("point0 temperature write lost");

endmodule

// File: sv/fci_cfg_regs.sv
// fci_cfg_regs: fan curve configuration registers and their write port
// depends on fci_pkg
module fci_cfg_regs import fci_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output curve_t                curve
);

	curve_t curve_q;

	assign cfg_ready = 1'b1;
	assign curve     = curve_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q <= CURVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POINT0_TEMP, REG_POINT1_TEMP, REG_POINT2_TEMP, REG_POINT3_TEMP: begin
					curve_q.temp[cfg_index[PT_IDX_W-1:0]] <= cfg_data[TEMP_W-1:0];
				end
				REG_POINT0_DUTY, REG_POINT1_DUTY, REG_POINT2_DUTY, REG_POINT3_DUTY: begin
					curve_q.duty[cfg_index[PT_IDX_W-1:0]] <= cfg_data[DUTY_W-1:0];
				end
				default: begin
					// index beyond the register list, write dropped
				end
			endcase
		end
	end

endmodule

// File: sv/fci_front.sv
// fci_front: segment search, operand select, products and numerator sum,
// pipeline stages s1 to s4; depends on fci_pkg
module fci_front import fci_pkg::*; #(
	parameter int NUM_POINTS = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic signed [TEMPC_W-1:0] temp_centi,
	input  curve_t                    curve,
	output logic                      out_valid,
	output div_req_t                  out_req
);

	localparam logic [SEG_W-1:0]    SEG_TOP = SEG_W'(NUM_POINTS);
	localparam logic [PT_IDX_W-1:0] LAST_PT = PT_IDX_W'(NUM_POINTS - 1);

	logic signed [X_W-1:0] x_arr [NUM_PTS_MAX];
	logic signed [X_W-1:0] t_ext;
	logic [SEG_W-1:0]      seg_c;

	logic                  vld_s1;
	logic signed [X_W-1:0] t_s1;
	logic [SEG_W-1:0]      seg_s1;

	logic [PT_IDX_W-1:0]    lo_idx;
	logic [PT_IDX_W-1:0]    hi_idx;
	logic signed [X_W-1:0]  dt_w;
	logic signed [X_W-1:0]  den_w;
	logic [DUTY_W-1:0]      y1_c;
	logic signed [DY_W-1:0] dy_c;
	logic [DEN_W-1:0]       den_c;
	logic [DEN_W-1:0]       dt_c;

	logic                   vld_s2;
	logic [DUTY_W-1:0]      y1_s2;
	logic signed [DY_W-1:0] dy_s2;
	logic [DEN_W-1:0]       den_s2;
	logic [DEN_W-1:0]       dt_s2;
	logic [SEG_W-1:0]       seg_s2;

	logic                   vld_s3;
	logic [NUM_W-1:0]       p1_s3;
	logic signed [P2_W-1:0] p2_s3;
	logic [DEN_W-1:0]       den_s3;
	logic [SEG_W-1:0]       seg_s3;

	logic signed [P2_W-1:0] sum_c;

	logic                   vld_s4;
	logic [NUM_W-1:0]       num_s4;
	logic [DEN_W-1:0]       den_s4;
	logic [SEG_W-1:0]       seg_s4;

	always_comb begin
		for (int i = 0; i < NUM_PTS_MAX; i++) begin
			x_arr[i] = scale_temp(curve.temp[i]);
		end
	end

	assign t_ext = X_W'(temp_centi);

	// below first point wins, then at-or-above last, then first point above t
	always_comb begin
		seg_c = SEG_W'(NUM_POINTS - 1);
		for (int i = NUM_POINTS - 2; i >= 1; i--) begin
			if (t_ext < x_arr[i]) seg_c = SEG_W'(i);
		end
		if (t_ext >= x_arr[LAST_PT]) seg_c = SEG_TOP;
		if (t_ext < x_arr[0]) seg_c = '0;
	end

	// edge segments run through the divider as y / 1
	always_comb begin
		hi_idx = seg_s1[PT_IDX_W-1:0];
		lo_idx = hi_idx - 1'b1;
		dt_w   = t_s1 - x_arr[lo_idx];
		den_w  = x_arr[hi_idx] - x_arr[lo_idx];
		priority if (seg_s1 == '0) begin
			y1_c  = curve.duty[0];
			dy_c  = '0;
			den_c = DEN_W'(1);
			dt_c  = '0;
		end else if (seg_s1 == SEG_TOP) begin
			y1_c  = curve.duty[LAST_PT];
			dy_c  = '0;
			den_c = DEN_W'(1);
			dt_c  = '0;
		end else begin
			y1_c  = curve.duty[lo_idx];
			dy_c  = signed'({1'b0, curve.duty[hi_idx]}) - signed'({1'b0, curve.duty[lo_idx]});
			den_c = den_w[DEN_W-1:0];
			dt_c  = dt_w[DEN_W-1:0];
		end
	end

	assign sum_c = signed'({2'b00, p1_s3}) + p2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t_ext;
			seg_s1 <= seg_c;

			y1_s2  <= y1_c;
			dy_s2  <= dy_c;
			den_s2 <= den_c;
			dt_s2  <= dt_c;
			seg_s2 <= seg_s1;

			p1_s3  <= NUM_W'(y1_s2) * NUM_W'(den_s2);
			p2_s3  <= P2_W'(dy_s2) * P2_W'(signed'({1'b0, dt_s2}));
			den_s3 <= den_s2;
			seg_s3 <= seg_s2;

			num_s4 <= sum_c[NUM_W-1:0];
			den_s4 <= den_s3;
			seg_s4 <= seg_s3;
		end
	end

	assign out_valid   = vld_s4;
	assign out_req.num = num_s4;
	assign out_req.den = den_s4;
	assign out_req.seg = seg_s4;

endmodule

// File: sv/fci_divider.sv
// fci_divider: restoring divider, one quotient bit per pipeline stage
// depends on fci_pkg
module fci_divider import fci_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  div_req_t          in_req,
	output logic              out_valid,
	output logic [Q_W-1:0]    out_quo,
	output logic [SEG_W-1:0]  out_seg
);

	logic [NUM_W-1:0] cur_rem [Q_W];
	logic [DEN_W-1:0] cur_den [Q_W];
	logic [Q_W-1:0]   cur_quo [Q_W];
	logic [SEG_W-1:0] cur_seg [Q_W];
	logic             cur_vld [Q_W];

	logic [NUM_W-1:0] nxt_rem [Q_W];
	logic [Q_W-1:0]   nxt_quo [Q_W];
	logic [NUM_W-1:0] shifted [Q_W];

	logic [NUM_W-1:0] rem_s [Q_W];
	logic [DEN_W-1:0] den_s [Q_W];
	logic [Q_W-1:0]   quo_s [Q_W];
	logic [SEG_W-1:0] seg_s [Q_W];
	logic             vld_s [Q_W];

	always_comb begin
		cur_rem[0] = in_req.num;
		cur_den[0] = in_req.den;
		cur_quo[0] = '0;
		cur_seg[0] = in_req.seg;
		cur_vld[0] = in_valid;
		for (int k = 1; k < Q_W; k++) begin
			cur_rem[k] = rem_s[k-1];
			cur_den[k] = den_s[k-1];
			cur_quo[k] = quo_s[k-1];
			cur_seg[k] = seg_s[k-1];
			cur_vld[k] = vld_s[k-1];
		end
	end

	// stage k settles quotient bit Q_W-1-k
	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			shifted[k] = NUM_W'(cur_den[k]) << (Q_W - 1 - k);
			if (cur_rem[k] >= shifted[k]) begin
				nxt_rem[k] = cur_rem[k] - shifted[k];
				nxt_quo[k] = {cur_quo[k][Q_W-2:0], 1'b1};
			end else begin
				nxt_rem[k] = cur_rem[k];
				nxt_quo[k] = {cur_quo[k][Q_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < Q_W; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < Q_W; k++) vld_s[k] <= cur_vld[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < Q_W; k++) begin
				rem_s[k] <= nxt_rem[k];
				den_s[k] <= cur_den[k];
				quo_s[k] <= nxt_quo[k];
				seg_s[k] <= cur_seg[k];
			end
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign out_quo   = quo_s[Q_W-1];
	assign out_seg   = seg_s[Q_W-1];

endmodule

// File: sv/fci_out_skid.sv
// fci_out_skid: output register with one skid entry, drives the pipeline enable
// depends on fci_pkg
module fci_out_skid import fci_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_valid,
	input  result_t res,
	output logic    pipe_en,
	output logic    m_valid,
	input  logic    m_ready,
	output result_t m_res
);

	logic    out_valid_q;
	logic    skid_full_q;
	result_t out_q;
	result_t skid_q;
	logic    take;
	logic    arrive;

	assign pipe_en = ~skid_full_q;
	assign take    = out_valid_q & m_ready;
	assign arrive  = res_valid & ~skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take) skid_full_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q <= arrive;
		end else if (arrive) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take) out_q <= skid_q;
		end else if (!out_valid_q || take) begin
			if (arrive) out_q <= res;
		end else if (arrive) begin
			skid_q <= res;
		end
	end

	assign m_valid = out_valid_q;
	assign m_res   = out_q;

endmodule

// File: test/fan_curve_interpolator_unit_test.sv
`timescale 1ns / 100ps
// fan_curve_interpolator_unit_test: self-checking bench for the fan curve interpolator
// drives temperature samples and curve register writes, predicts duty and segment
// depends on fci_pkg and fan_curve_interpolator_unit
module fan_curve_interpolator_unit_test;
	import fci_pkg::*;

	localparam int CURVE_POINTS     = 4;
	localparam int DUTY_LIMIT       = 256;
	localparam int DRAIN_CYCLES     = 40;   // pipeline is 14 deep, plus skid
	localparam int FIRST_UNUSED_REG = int'(REG_POINT3_DUTY) + 1;
	localparam int LAST_CFG_INDEX   = (1 << CFG_IDX_W) - 1;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// samples waiting to be sent, and duty results the block still owes
	logic [S_DATA_W-1:0] temp_samples[$];
	result_t             pending_duties[$];
	result_t             want;

	// shadow of the curve registers, temperatures sign extended
	int curve_temp[CURVE_POINTS] = '{30, 40, 50, 60};
	int curve_duty[CURVE_POINTS] = '{64, 128, 192, 256};

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;

	fan_curve_interpolator_unit #(
		.NUM_POINTS(CURVE_POINTS),
		.DUTY_MAX  (DUTY_LIMIT)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// piecewise linear mapping of one sample in hundredths of a degree
	function automatic result_t map_temperature(input logic signed [TEMPC_W-1:0] centi);
		int t, x1, x2, y1, y2, num, den, d, seg, i;
		result_t r;
		t = centi;
		if (t < curve_temp[0] * 100) begin
			seg = 0;
			d   = curve_duty[0];
		end else if (t >= curve_temp[CURVE_POINTS-1] * 100) begin
			seg = CURVE_POINTS;
			d   = curve_duty[CURVE_POINTS-1];
		end else begin
			// first point above the sample closes the bracket, so den > 0
			i = 1;
			while (i < CURVE_POINTS - 1 && t >= curve_temp[i] * 100)
				i++;
			seg = i;
			x1  = curve_temp[i-1] * 100;
			x2  = curve_temp[i] * 100;
			y1  = curve_duty[i-1];
			y2  = curve_duty[i];
			den = x2 - x1;
			num = y1 * den + (y2 - y1) * (t - x1);
			d   = num / den;    // truncates toward zero
		end
		// clamp holds in every segment, out-of-range duty registers included
		if (d < 1)
			d = 1;
		else if (d > DUTY_LIMIT)
			d = DUTY_LIMIT;
		r.duty = d[DUTY_W-1:0];
		r.seg  = seg[SEG_W-1:0];
		return r;
	endfunction

	// sender: presents queued samples, predicts each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_duties.insert(pending_duties.size(),
					map_temperature(s_tdata[TEMPC_W-1:0]));
				temp_samples.delete(0);
			end
			if (!s_tvalid || s_tready) begin
				if (temp_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= temp_samples[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure, every taken result checked against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_duties.size() == 0) begin
					$display("%0t: result with nothing owed, duty %0d segment %0d", $time,
						m_tdata[DUTY_W-1:0], m_tdata[DUTY_W+SEG_W-1:DUTY_W]);
					mismatch_count++;
				end else begin
					want = pending_duties.pop_front();
					if (m_tdata[DUTY_W-1:0] !== want.duty) begin
						$display("%0t: duty expected %0d actual %0d", $time,
							want.duty, m_tdata[DUTY_W-1:0]);
						mismatch_count++;
					end
					if (m_tdata[DUTY_W+SEG_W-1:DUTY_W] !== want.seg) begin
						$display("%0t: segment expected %0d actual %0d", $time,
							want.seg, m_tdata[DUTY_W+SEG_W-1:DUTY_W]);
						mismatch_count++;
					end
					if (m_tdata[M_DATA_W-1:DUTY_W+SEG_W] !== '0) begin
						$display("%0t: pad bits expected 0 actual %h", $time,
							m_tdata[M_DATA_W-1:DUTY_W+SEG_W]);
						mismatch_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic push_sample(input int t);
		temp_samples.insert(temp_samples.size(), {1'b0, t[TEMPC_W-1:0]});
	endtask

	// sender holds off until every owed result is back and the pipeline is flushed
	task automatic wait_drained();
		while (temp_samples.size() != 0 || s_tvalid || pending_duties.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// starts on a rising edge; each write is held until its handshake
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx < REG_POINT0_DUTY)
			curve_temp[idx[PT_IDX_W-1:0]] = $signed(val[TEMP_W-1:0]);
		else if (idx <= REG_POINT3_DUTY)
			curve_duty[idx[PT_IDX_W-1:0]] = val;
	endtask

	// full curve load, with one write to an unused index that must be ignored
	task automatic set_curve(input int t0, t1, t2, t3, d0, d1, d2, d3);
		@(posedge clk);
		write_reg(REG_POINT0_TEMP, {1'($urandom_range(1)), t0[TEMP_W-1:0]});
		write_reg(REG_POINT1_TEMP, {1'($urandom_range(1)), t1[TEMP_W-1:0]});
		write_reg(REG_POINT2_TEMP, {1'($urandom_range(1)), t2[TEMP_W-1:0]});
		write_reg(REG_POINT3_TEMP, {1'($urandom_range(1)), t3[TEMP_W-1:0]});
		write_reg(CFG_IDX_W'($urandom_range(LAST_CFG_INDEX, FIRST_UNUSED_REG)),
			CFG_DATA_W'($urandom));
		write_reg(REG_POINT0_DUTY, d0[DUTY_W-1:0]);
		write_reg(REG_POINT1_DUTY, d1[DUTY_W-1:0]);
		write_reg(REG_POINT2_DUTY, d2[DUTY_W-1:0]);
		write_reg(REG_POINT3_DUTY, d3[DUTY_W-1:0]);
		cfg_valid <= 1'b0;
	endtask

	// queues one phase of samples; random ones cluster around the curve points
	task automatic run_phase(input int n_random, input int send_pct, input int recv_pct,
			input bit with_directed);
		int k, pick;
		@(negedge clk);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		if (with_directed) begin
			// just below, on and just above every point, then the field and range ends
			for (k = 0; k < CURVE_POINTS; k++) begin
				push_sample(curve_temp[k] * 100 - 1);
				push_sample(curve_temp[k] * 100);
				push_sample(curve_temp[k] * 100 + 1);
			end
			push_sample(-(1 << (TEMPC_W - 1)));
			push_sample((1 << (TEMPC_W - 1)) - 1);
			push_sample(-4000);
			push_sample(12500);
			push_sample(0);
		end
		for (k = 0; k < n_random; k++) begin
			pick = $urandom_range(99);
			if (pick < 60)
				push_sample(curve_temp[$urandom_range(CURVE_POINTS - 1)] * 100
					+ int'($urandom_range(400)) - 200);
			else if (pick < 85)
				push_sample(int'($urandom_range(16500)) - 4000);
			else
				push_sample(int'($urandom));
		end
	endtask

	initial begin
		int phase, base;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset curve first
		run_phase(175, 32, 55, 1'b1);

		for (phase = 1; phase <= 8; phase++) begin
			wait_drained();
			case (phase)
				// extreme temperatures, duty registers outside the clamp range
				1: set_curve(-128, -1, 0, 127, 1, 256, 0, 511);
				2: begin
					base = int'($urandom_range(60)) - 40;
					set_curve(base, base + 1 + $urandom_range(20), base + 25 + $urandom_range(20),
						base + 50 + $urandom_range(35), 1 + $urandom_range(255),
						1 + $urandom_range(255), 1 + $urandom_range(255), 1 + $urandom_range(255));
				end
				// points in arbitrary order, any 9-bit duty
				3, 4: set_curve(int'($urandom_range(255)) - 128, int'($urandom_range(255)) - 128,
					int'($urandom_range(255)) - 128, int'($urandom_range(255)) - 128,
					$urandom_range(511), $urandom_range(511), $urandom_range(511),
					$urandom_range(511));
				// coincident points, steep alternating slopes
				5: begin
					base = int'($urandom_range(100)) - 40;
					set_curve(base, base, base + 1, base + 1, 256, 1, 256, 1);
				end
				// one degree segments
				6: begin
					base = int'($urandom_range(140)) - 40;
					set_curve(base, base + 1, base + 2, base + 3, 1 + $urandom_range(255),
						1 + $urandom_range(255), 1 + $urandom_range(255), 1 + $urandom_range(255));
				end
				// every point at the bottom of the register range, zero duties
				7: set_curve(-128, -128, -128, -128, 0, 0, 0, 0);
				default: set_curve(-128 + int'($urandom_range(40)), -20 + int'($urandom_range(20)),
					40 + int'($urandom_range(20)), 100 + int'($urandom_range(27)),
					1 + $urandom_range(255), 1 + $urandom_range(255), 1 + $urandom_range(255),
					1 + $urandom_range(255));
			endcase
			if (phase <= 3)
				run_phase(175, 32, 55, phase == 1);
			else if (phase <= 6)
				run_phase(175, 55, 32, 1'b0);
			else
				run_phase(175, 0, 0, 1'b0);
		end

		wait_drained();
		if (pending_duties.size() != 0)
			$display("%0t: %0d results never arrived", $time, pending_duties.size());
		if (mismatch_count == 0 && pending_duties.size() == 0) begin
			$display("fan_curve_interpolator_unit verification clean");
		end else begin
			$display("fan_curve_interpolator_unit verification failed");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("fan_curve_interpolator_unit verification failed");
		$finish;
	end

endmodule
